[hdl/grid_bfs_shortest_path_core_macros.svh]
// Assertion macros for the grid shortest-path core.
// Assumes clk_i and rst_ni are in scope where the macros are used.
`ifndef GRID_BFS_SHORTEST_PATH_CORE_MACROS_SVH
`define GRID_BFS_SHORTEST_PATH_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GBSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define GBSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/gbsp_pkg.sv]
// Package for the grid shortest-path core: sizes, codes and state types.
// No dependencies.
package gbsp_pkg;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;
  localparam int CFG_W        = 6;
  localparam int PL_W         = 10;
  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(32);

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  localparam logic [1:0] CELL_OPEN  = 2'd0;
  localparam logic [1:0] CELL_WALL  = 2'd1;
  localparam logic [1:0] CELL_START = 2'd2;
  localparam logic [1:0] CELL_GOAL  = 2'd3;

  localparam logic [1:0] KIND_CELL   = 2'd0;
  localparam logic [1:0] KIND_RESULT = 2'd1;
  localparam logic [1:0] KIND_MOVE   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef enum logic {
    PH_LOAD,
    PH_DELIVER
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_DIV,
    S_INIT,
    S_POP,
    S_CUR,
    S_NB,
    S_CHK,
    S_BACK,
    S_BSTEP,
    S_RES,
    S_FETCH
  } state_e;

endpackage

[hdl/grid_bfs_shortest_path_core.sv]
// Grid shortest-path core: cell loader, breadth-first search sequencer, path fetch.
// Depends on gbsp_pkg and grid_bfs_shortest_path_core_macros.svh.
//
// Load the grid one cell per transaction in row-major order (func 0); each load
// answers kind 0. The load marked last_cell runs the search and answers kind 1
// with found and path_length. The search is run by one small sequencer over
// memories with one write and one registered read port each: a clearing pass
// over the visited map of the cells in use, a restoring division of the start
// index by cols (one bit per cycle), then the dequeue of each cell, a check of
// each neighbor that lies inside the grid, and a walk of the parents that
// stores each move of the path.
// Fetch transactions (func 1) return the moves from start to goal, one per
// transaction, or kind 3 when no move is left. The core takes one transaction
// at a time and is not ready while a search or fetch is running.
`include "grid_bfs_shortest_path_core_macros.svh"

module grid_bfs_shortest_path_core #(
  parameter int MAX_ROWS = gbsp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gbsp_pkg::MAX_COLS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [gbsp_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      func_i,
  input  logic [1:0]                cell_req_i,
  input  logic                      last_cell_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                kind_o,
  output logic                      found_o,
  output logic [gbsp_pkg::PL_W-1:0] path_length_o,
  output logic [1:0]                move_o,
  output logic                      last_move_o
);

  localparam int CW    = gbsp_pkg::CFG_W;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int IW    = (CELLS < 4) ? 2 : $clog2(CELLS);
  localparam int TW    = $clog2(CELLS + 1) + 1;
  localparam int QW    = 2 * CW + IW;
  localparam int DCW   = $clog2(IW + 1);

  // Memories
  logic           bm_mem [CELLS];
  logic           seen_mem [CELLS];
  logic [1:0]     par_mem [CELLS];
  logic [QW-1:0]  q_mem [CELLS];
  logic [1:0]     pm_mem [CELLS];

  logic           bm_we, bm_wd, bm_re, bm_rd_q;
  logic [IW-1:0]  bm_wa, bm_ra;
  logic           seen_we, seen_wd, seen_re, seen_rd_q;
  logic [IW-1:0]  seen_wa, seen_ra;
  logic           par_we, par_re;
  logic [1:0]     par_wd, par_rd_q;
  logic [IW-1:0]  par_wa, par_ra;
  logic           q_we, q_re;
  logic [QW-1:0]  q_wd, q_rd_q;
  logic [IW-1:0]  q_wa, q_ra;
  logic           pm_we, pm_re;
  logic [1:0]     pm_wd, pm_rd_q;
  logic [IW-1:0]  pm_wa, pm_ra;

  // Control and datapath registers
  gbsp_pkg::state_e state_q, state_d;
  gbsp_pkg::phase_e phase_q, phase_d;
  logic [CW-1:0]  rows_q, cols_q;
  logic [TW-1:0]  lc_q, lc_d;
  logic [IW-1:0]  start_q, start_d, goal_q, goal_d;
  logic [IW-1:0]  src_q, src_d, dst_q, dst_d;
  logic [TW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [TW-1:0]  cnt_q, cnt_d;
  logic [1:0]     dir_q, dir_d;
  logic [IW-1:0]  nb_q, nb_d;
  logic [CW-1:0]  nbr_q, nbr_d, nbc_q, nbc_d;
  logic [IW-1:0]  dnum_q, dnum_d;
  logic [CW-1:0]  drem_q, drem_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic [IW-1:0]  p_q, p_d;
  logic [TW-1:0]  pc_q, pc_d, rp_q, rp_d;
  logic           found_q, found_d;
  logic           lm_q, lm_d;

  logic               ovalid_q, ovalid_d;
  logic [1:0]         okind_q, okind_d, omove_q, omove_d;
  logic               ofound_q, ofound_d, olast_q, olast_d;
  logic [gbsp_pkg::PL_W-1:0] olen_q, olen_d;

  // Effective grid size
  logic [CW-1:0]   nr, nc;
  logic [2*CW-1:0] prod;
  logic [TW-1:0]   total;

  always_comb begin
    if (rows_q == '0) nr = CW'(1);
    else if (int'(rows_q) > MAX_ROWS) nr = CW'(MAX_ROWS);
    else nr = rows_q;
    if (cols_q == '0) nc = CW'(1);
    else if (int'(cols_q) > MAX_COLS) nc = CW'(MAX_COLS);
    else nc = cols_q;
  end

  assign prod  = (2*CW)'(nr) * (2*CW)'(nc);
  assign total = TW'(prod);

  // Current queue entry
  logic [CW-1:0] cur_r, cur_c;
  logic [IW-1:0] cur_i;
  assign {cur_r, cur_c, cur_i} = q_rd_q;

  logic out_free, in_acc;
  assign out_free   = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == gbsp_pkg::S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= gbsp_pkg::DIM_RESET;
      cols_q <= gbsp_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gbsp_pkg::REG_ROWS: rows_q <= cfg_wdata_i;
        gbsp_pkg::REG_COLS: cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  logic [CW:0]   dtrial;
  logic          dge;
  logic          nb_ok;
  logic [IW-1:0] nb_i;
  logic [CW-1:0] nb_r, nb_c;
  logic [TW-1:0] lc_base;
  logic [IW-1:0] p_back;
  logic          nb_free;

  always_comb begin
    dtrial = {drem_q, dnum_q[IW-1]};
    dge    = dtrial >= {1'b0, nc};

    // Neighbor in the current direction
    nb_ok = 1'b0;
    nb_i  = cur_i;
    nb_r  = cur_r;
    nb_c  = cur_c;
    case (dir_q)
      gbsp_pkg::DIR_RIGHT: begin
        nb_ok = ({1'b0, cur_c} + (CW+1)'(1)) < {1'b0, nc};
        nb_i  = cur_i + IW'(1);
        nb_c  = cur_c + CW'(1);
      end
      gbsp_pkg::DIR_LEFT: begin
        nb_ok = cur_c != '0;
        nb_i  = cur_i - IW'(1);
        nb_c  = cur_c - CW'(1);
      end
      gbsp_pkg::DIR_DOWN: begin
        nb_ok = ({1'b0, cur_r} + (CW+1)'(1)) < {1'b0, nr};
        nb_i  = cur_i + IW'(nc);
        nb_r  = cur_r + CW'(1);
      end
      default: begin
        nb_ok = cur_r != '0;
        nb_i  = cur_i - IW'(nc);
        nb_r  = cur_r - CW'(1);
      end
    endcase

    case (par_rd_q)
      gbsp_pkg::DIR_RIGHT: p_back = p_q - IW'(1);
      gbsp_pkg::DIR_LEFT:  p_back = p_q + IW'(1);
      gbsp_pkg::DIR_DOWN:  p_back = p_q - IW'(nc);
      default:             p_back = p_q + IW'(nc);
    endcase

    nb_free = !seen_rd_q && !((TW'(nb_q) >= lc_q) || bm_rd_q);
    lc_base = (phase_q == gbsp_pkg::PH_DELIVER) ? '0 : lc_q;

    state_d = state_q;  phase_d = phase_q;  lc_d = lc_q;
    start_d = start_q;  goal_d = goal_q;   src_d = src_q;  dst_d = dst_q;
    head_d = head_q;    tail_d = tail_q;   cnt_d = cnt_q;  dir_d = dir_q;
    nb_d = nb_q;        nbr_d = nbr_q;     nbc_d = nbc_q;
    dnum_d = dnum_q;    drem_d = drem_q;   dcnt_d = dcnt_q;
    p_d = p_q;          pc_d = pc_q;       rp_d = rp_q;
    found_d = found_q;  lm_d = lm_q;
    ovalid_d = ovalid_q && !out_ready_i;
    okind_d = okind_q;  ofound_d = ofound_q; olen_d = olen_q;
    omove_d = omove_q;  olast_d = olast_q;

    bm_we = 1'b0;  bm_wa = '0;  bm_wd = 1'b0;  bm_re = 1'b0;  bm_ra = nb_i;
    seen_we = 1'b0; seen_wa = '0; seen_wd = 1'b0; seen_re = 1'b0; seen_ra = nb_i;
    par_we = 1'b0; par_wa = nb_q; par_wd = dir_q; par_re = 1'b0; par_ra = p_q;
    q_we = 1'b0;   q_wa = IW'(tail_q); q_wd = {nbr_q, nbc_q, nb_q};
    q_re = 1'b0;   q_ra = IW'(head_q);
    pm_we = 1'b0;  pm_wa = IW'(cnt_q); pm_wd = par_rd_q;
    pm_re = 1'b0;  pm_ra = IW'(pc_q - rp_q - TW'(1));

    case (state_q)
      gbsp_pkg::S_IDLE: begin
        if (in_acc) begin
          if (func_i == gbsp_pkg::FUNC_LOAD) begin
            phase_d = gbsp_pkg::PH_LOAD;
            lc_d    = lc_base;
            if (phase_q == gbsp_pkg::PH_DELIVER) begin
              start_d = '0;
              goal_d  = '0;
            end
            if (lc_base < total) begin
              bm_we = 1'b1;
              bm_wa = IW'(lc_base);
              bm_wd = cell_req_i == gbsp_pkg::CELL_WALL;
              if (cell_req_i == gbsp_pkg::CELL_START) start_d = IW'(lc_base);
              if (cell_req_i == gbsp_pkg::CELL_GOAL)  goal_d  = IW'(lc_base);
              lc_d = lc_base + TW'(1);
            end
            if (last_cell_i) begin
              cnt_d   = '0;
              state_d = gbsp_pkg::S_CLR;
            end else begin
              ovalid_d = 1'b1;
              okind_d  = gbsp_pkg::KIND_CELL;
              ofound_d = 1'b0;
              olen_d   = '0;
              omove_d  = '0;
              olast_d  = 1'b0;
            end
          end else if (phase_q == gbsp_pkg::PH_DELIVER && rp_q < pc_q) begin
            pm_re   = 1'b1;
            lm_d    = (rp_q + TW'(1)) == pc_q;
            rp_d    = rp_q + TW'(1);
            state_d = gbsp_pkg::S_FETCH;
          end else begin
            ovalid_d = 1'b1;
            okind_d  = gbsp_pkg::KIND_NONE;
            ofound_d = 1'b0;
            olen_d   = '0;
            omove_d  = '0;
            olast_d  = 1'b0;
          end
        end
      end
      gbsp_pkg::S_CLR: begin
        // Sweep the visited map over the cells in use
        seen_we = 1'b1;
        seen_wa = IW'(cnt_q);
        seen_wd = 1'b0;
        cnt_d   = cnt_q + TW'(1);
        if (cnt_q + TW'(1) >= total) begin
          src_d   = (TW'(start_q) < total) ? start_q : '0;
          dst_d   = (TW'(goal_q) < total) ? goal_q : '0;
          dnum_d  = (TW'(start_q) < total) ? start_q : '0;
          drem_d  = '0;
          dcnt_d  = '0;
          state_d = gbsp_pkg::S_DIV;
        end
      end
      gbsp_pkg::S_DIV: begin
        // One quotient bit per cycle: start index into row and column
        drem_d = dge ? CW'(dtrial - {1'b0, nc}) : CW'(dtrial);
        dnum_d = {dnum_q[IW-2:0], dge};
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(IW - 1)) state_d = gbsp_pkg::S_INIT;
      end
      gbsp_pkg::S_INIT: begin
        seen_we = 1'b1;
        seen_wa = src_q;
        seen_wd = 1'b1;
        q_we    = 1'b1;
        q_wa    = '0;
        q_wd    = {CW'(dnum_q), drem_q, src_q};
        head_d  = '0;
        tail_d  = TW'(1);
        state_d = gbsp_pkg::S_POP;
      end
      gbsp_pkg::S_POP: begin
        if (head_q == tail_q) begin
          found_d = 1'b0;
          cnt_d   = '0;
          state_d = gbsp_pkg::S_RES;
        end else begin
          q_re    = 1'b1;
          head_d  = head_q + TW'(1);
          state_d = gbsp_pkg::S_CUR;
        end
      end
      gbsp_pkg::S_CUR: begin
        if (cur_i == dst_q) begin
          found_d = 1'b1;
          p_d     = dst_q;
          cnt_d   = '0;
          state_d = gbsp_pkg::S_BACK;
        end else begin
          dir_d   = gbsp_pkg::DIR_RIGHT;
          state_d = gbsp_pkg::S_NB;
        end
      end
      gbsp_pkg::S_NB: begin
        if (nb_ok) begin
          bm_re   = 1'b1;
          seen_re = 1'b1;
          nb_d    = nb_i;
          nbr_d   = nb_r;
          nbc_d   = nb_c;
          state_d = gbsp_pkg::S_CHK;
        end else if (dir_q == gbsp_pkg::DIR_UP) begin
          state_d = gbsp_pkg::S_POP;
        end else begin
          dir_d = dir_q + 2'd1;
        end
      end
      gbsp_pkg::S_CHK: begin
        if (nb_free) begin
          seen_we = 1'b1;
          seen_wa = nb_q;
          seen_wd = 1'b1;
          par_we  = 1'b1;
          q_we    = 1'b1;
          tail_d  = tail_q + TW'(1);
        end
        if (dir_q == gbsp_pkg::DIR_UP) begin
          state_d = gbsp_pkg::S_POP;
        end else begin
          dir_d   = dir_q + 2'd1;
          state_d = gbsp_pkg::S_NB;
        end
      end
      gbsp_pkg::S_BACK: begin
        // Walk parents from goal back to start; moves land in reverse order
        if (p_q == src_q || cnt_q >= total) begin
          state_d = gbsp_pkg::S_RES;
        end else begin
          par_re  = 1'b1;
          state_d = gbsp_pkg::S_BSTEP;
        end
      end
      gbsp_pkg::S_BSTEP: begin
        pm_we   = 1'b1;
        p_d     = p_back;
        cnt_d   = cnt_q + TW'(1);
        state_d = gbsp_pkg::S_BACK;
      end
      gbsp_pkg::S_RES: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = gbsp_pkg::KIND_RESULT;
          ofound_d = found_q;
          olen_d   = gbsp_pkg::PL_W'(cnt_q);
          omove_d  = '0;
          olast_d  = 1'b0;
          pc_d     = cnt_q;
          rp_d     = '0;
          phase_d  = gbsp_pkg::PH_DELIVER;
          state_d  = gbsp_pkg::S_IDLE;
        end
      end
      gbsp_pkg::S_FETCH: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = gbsp_pkg::KIND_MOVE;
          ofound_d = 1'b0;
          olen_d   = '0;
          omove_d  = pm_rd_q;
          olast_d  = lm_q;
          state_d  = gbsp_pkg::S_IDLE;
        end
      end
      default: state_d = gbsp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gbsp_pkg::S_IDLE;
      phase_q  <= gbsp_pkg::PH_LOAD;
      lc_q     <= '0;
      start_q  <= '0;
      goal_q   <= '0;
      rp_q     <= '0;
      pc_q     <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      dcnt_q   <= '0;
      dir_q    <= gbsp_pkg::DIR_RIGHT;
      found_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      lc_q     <= lc_d;
      start_q  <= start_d;
      goal_q   <= goal_d;
      rp_q     <= rp_d;
      pc_q     <= pc_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      dcnt_q   <= dcnt_d;
      dir_q    <= dir_d;
      found_q  <= found_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    dst_q    <= dst_d;
    nb_q     <= nb_d;
    nbr_q    <= nbr_d;
    nbc_q    <= nbc_d;
    dnum_q   <= dnum_d;
    drem_q   <= drem_d;
    p_q      <= p_d;
    lm_q     <= lm_d;
    okind_q  <= okind_d;
    ofound_q <= ofound_d;
    olen_q   <= olen_d;
    omove_q  <= omove_d;
    olast_q  <= olast_d;
  end

  // Memory ports: one write, one registered read each
  always_ff @(posedge clk_i) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    if (bm_re) bm_rd_q <= bm_mem[bm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (seen_we) seen_mem[seen_wa] <= seen_wd;
    if (seen_re) seen_rd_q <= seen_mem[seen_ra];
  end

  always_ff @(posedge clk_i) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    if (par_re) par_rd_q <= par_mem[par_ra];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    if (q_re) q_rd_q <= q_mem[q_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) pm_mem[pm_wa] <= pm_wd;
    if (pm_re) pm_rd_q <= pm_mem[pm_ra];
  end

  assign out_valid_o   = ovalid_q;
  assign kind_o        = okind_q;
  assign found_o       = ofound_q;
  assign path_length_o = olen_q;
  assign move_o        = omove_q;
  assign last_move_o   = olast_q;

  `GBSP_ASSERT(a_ready_idle, in_ready_o |-> (state_q == gbsp_pkg::S_IDLE), "ready outside idle")
  `GBSP_ASSERT(a_queue_order, (state_q == gbsp_pkg::S_POP) |-> (head_q <= tail_q), "queue head passed tail")
  `GBSP_ASSERT(a_queue_bound, (state_q == gbsp_pkg::S_CHK && nb_free) |-> (tail_q < total), "queue overflow")
  `GBSP_ASSERT(a_fetch_len, (state_q == gbsp_pkg::S_FETCH) |-> (rp_q <= pc_q && rp_q != '0), "fetch past path end")

endmodule
